// ----- hw/rtl/frame_stamped_query_cache_top_macros.svh -----
// assertion macros for the frame-stamped query cache
`ifndef FRAME_STAMPED_QUERY_CACHE_TOP_MACROS_SVH
`define FRAME_STAMPED_QUERY_CACHE_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, quiet while in reset
`define FSQC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, quiet while in reset
`define FSQC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/fsqc_pkg.sv -----
// shared types and constants of the frame-stamped query cache
package fsqc_pkg;

	localparam int POS_W    = 32;
	localparam int RAD_W    = 24;
	localparam int FRAME_W  = 32;
	localparam int ENTITY_W = 32;
	localparam int OUT_ID_W = 32;
	localparam int KEY_W    = 64;

	// one 8-pixel cell is 128 units of 1/16 pixel
	localparam int CELL_SHIFT = 7;
	localparam logic signed [POS_W-1:0] CELL_BIAS = POS_W'((1 << CELL_SHIFT) - 1);
	localparam int QY_SHIFT = 16;
	localparam int QR_SHIFT = 32;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_STORE  = 1'b1;

	typedef struct packed {
		logic                    opcode;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic [RAD_W-1:0]        radius;
		logic [FRAME_W-1:0]      frame_number;
		logic                    first_of_list;
		logic                    entity_present;
		logic [ENTITY_W-1:0]     entity_id;
	} in_t;

	typedef struct packed {
		logic                hit;
		logic [OUT_ID_W-1:0] found_id;
		logic                id_valid;
		logic                last;
	} out_t;

	typedef struct packed {
		logic accept;
		logic clr_wr;
		logic mod_step;
		logic store_wr;
		logic tag_rd;
		logic id_rd_first;
		logic id_rd_next;
		logic out_single;
		logic out_id;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic line_direct;
		logic in_store;
		logic item_store;
		logic mod_done;
		logic hit;
		logic empty;
		logic last_id;
		logic out_free;
	} sts_t;

endpackage

// ----- hw/rtl/frame_stamped_query_cache_top.sv -----
// top level of the frame-stamped query cache
//
//  channel   direction  handshake            payload
//  in        sink       in_valid / in_ready  in_data  (fsqc_pkg::in_t)
//  out       source     out_valid/out_ready  out_data (fsqc_pkg::out_t)
//
// after reset a clearing pass writes every tag line to zero,
// with in_ready low for the whole pass
// with LINES a power of two a store is written while the next transfer is
// taken; a lookup reads and compares the tag line, then for a hit reads out
// its ids, which leave one per cycle while out_ready stays high
// with any other LINES the line index comes from an iterative key reduction,
// 4 key bits per cycle, run before every item is written or looked up
// a stalled result sits in the output register; the block waits on it only
// when it has the next result ready
`include "frame_stamped_query_cache_top_macros.svh"

module frame_stamped_query_cache_top #(
	parameter int LINES   = 64,
	parameter int MAX_IDS = 32,
	parameter int ID_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  fsqc_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output fsqc_pkg::out_t out_data
);
	import fsqc_pkg::*;

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: clearing pass, line reduction, store write, lookup and id readout
	fsqc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: key forming, tag and id rams, open line mirror, output register
	fsqc_dp #(
		.LINES   (LINES),
		.MAX_IDS (MAX_IDS),
		.ID_BITS (ID_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// no transfer is taken while the tag ram is being cleared
	`FSQC_ASSERT_NOW(a_no_accept_in_clear, cmd.clr_wr, !in_ready, "transfer taken during clear")

	// a result is never loaded over one that has not been taken
	`FSQC_ASSERT_NOW(a_no_result_overwrite, cmd.out_single || cmd.out_id, sts.out_free,
		"pending result overwritten")

	// tag ram ports are used by one operation at a time
	`FSQC_ASSERT_NOW(a_tag_port_exclusive, 1'b1, $onehot0({cmd.clr_wr, cmd.store_wr, cmd.tag_rd}),
		"tag ram access conflict")

	// a lookup holds the block until its last result is loaded into the output register
	`FSQC_ASSERT_NEXT(a_lookup_blocks, in_valid && in_ready && (in_data.opcode == OP_LOOKUP),
		!in_ready, "transfer taken during lookup")

endmodule

// ----- hw/rtl/fsqc_ram.sv -----
// generic single-write, single-read ram with registered read data
module fsqc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/fsqc_ctrl.sv -----
// controller state machine of the frame-stamped query cache
module fsqc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  fsqc_pkg::sts_t sts,
	output fsqc_pkg::cmd_t cmd
);
	import fsqc_pkg::*;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_MOD  = 3'd2;
	localparam logic [2:0] S_WR   = 3'd3;
	localparam logic [2:0] S_RD   = 3'd4;
	localparam logic [2:0] S_CMP  = 3'd5;
	localparam logic [2:0] S_LD   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// a store write overlaps the transfer of the next item
	assign in_ready = (state_q == S_IDLE) || (state_q == S_WR);

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.accept = in_valid && in_ready;
		unique case (state_q) inside
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE, S_WR: begin
				cmd.store_wr = (state_q == S_WR);
				if (!cmd.accept) begin
					state_d = S_IDLE;
				end else if (!sts.line_direct) begin
					state_d = S_MOD;
				end else if (sts.in_store == OP_STORE) begin
					state_d = S_WR;
				end else begin
					state_d = S_RD;
				end
			end
			S_MOD: begin
				if (!sts.mod_done) begin
					cmd.mod_step = 1'b1;
				end else if (sts.item_store == OP_STORE) begin
					state_d = S_WR;
				end else begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.tag_rd = 1'b1;
				state_d    = S_CMP;
			end
			S_CMP: begin
				if (sts.hit && !sts.empty) begin
					cmd.id_rd_first = 1'b1;
					state_d         = S_LD;
				end else if (sts.out_free) begin
					cmd.out_single = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_LD: begin
				if (sts.out_free) begin
					cmd.out_id = 1'b1;
					if (sts.last_id) begin
						state_d = S_IDLE;
					end else begin
						cmd.id_rd_next = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hw/rtl/fsqc_dp.sv -----
// datapath of the frame-stamped query cache: key, line reduction, rams, result register
module fsqc_dp #(
	parameter int LINES   = 64,
	parameter int MAX_IDS = 32,
	parameter int ID_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  fsqc_pkg::in_t  in_data,
	input  fsqc_pkg::cmd_t cmd,
	output fsqc_pkg::sts_t sts,
	output logic           out_valid,
	input  logic           out_ready,
	output fsqc_pkg::out_t out_data
);
	import fsqc_pkg::*;

	localparam int  LW        = $clog2(LINES);
	localparam bit  DIRECT    = (LINES & (LINES - 1)) == 0;
	localparam int  CW        = $clog2(MAX_IDS + 1);
	localparam int  IW        = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
	localparam int  SW        = (ID_BITS < OUT_ID_W) ? ID_BITS : OUT_ID_W;
	localparam int  TAG_W     = KEY_W + FRAME_W + CW + 1;
	localparam int  ID_DEPTH  = LINES * (2 ** IW);
	localparam int  DIG_BITS  = 4;
	localparam int  DIGITS    = KEY_W / DIG_BITS;
	localparam int  MCW       = $clog2(DIGITS + 1);

	function automatic logic [KEY_W-1:0] cell_key(
		input logic signed [POS_W-1:0] px,
		input logic signed [POS_W-1:0] py,
		input logic [RAD_W-1:0]        pr
	);
		logic signed [POS_W-1:0] sx;
		logic signed [POS_W-1:0] sy;
		logic signed [POS_W-1:0] qx;
		logic signed [POS_W-1:0] qy;
		logic [KEY_W-1:0]        kx;
		logic [KEY_W-1:0]        ky;
		logic [KEY_W-1:0]        kr;
		// truncation toward zero: bias negatives before the arithmetic shift
		sx = px + (px[POS_W-1] ? CELL_BIAS : '0);
		sy = py + (py[POS_W-1] ? CELL_BIAS : '0);
		qx = sx >>> CELL_SHIFT;
		qy = sy >>> CELL_SHIFT;
		kx = {{(KEY_W-POS_W){qx[POS_W-1]}}, qx};
		ky = {{(KEY_W-POS_W){qy[POS_W-1]}}, qy};
		kr = KEY_W'(pr >> CELL_SHIFT);
		return kx ^ (ky << QY_SHIFT) ^ (kr << QR_SHIFT);
	endfunction

	// item registers
	logic               opcode_q;
	logic [KEY_W-1:0]   key_q;
	logic [FRAME_W-1:0] frame_q;
	logic               first_q;
	logic               present_q;
	logic [SW-1:0]      eid_q;

	// line reduction
	logic [KEY_W-1:0] mod_sh_q;
	logic [LW:0]      mod_r_q;
	logic [LW:0]      mod_r_d;
	logic [LW:0]      mod_acc;
	logic [MCW-1:0]   mod_cnt_q;
	logic [LW-1:0]    line;

	// open line mirror
	logic [LW-1:0]      open_line_q;
	logic [KEY_W-1:0]   open_key_q;
	logic [FRAME_W-1:0] open_frame_q;
	logic [CW-1:0]      open_cnt_q;
	logic               open_ovf_q;

	logic [LW-1:0]      st_line;
	logic [KEY_W-1:0]   st_key;
	logic [FRAME_W-1:0] st_frame;
	logic [CW-1:0]      base_cnt;
	logic               base_ovf;
	logic               room;
	logic [CW-1:0]      new_cnt;
	logic               new_ovf;

	logic [LW-1:0]      clr_idx_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      idx_next;

	logic               tag_we;
	logic [LW-1:0]      tag_wr_addr;
	logic [TAG_W-1:0]   tag_wr_data;
	logic [TAG_W-1:0]   tag_rd_data;
	logic [KEY_W-1:0]   tag_key;
	logic [FRAME_W-1:0] tag_frame;
	logic [CW-1:0]      tag_cnt;
	logic               tag_ovf;

	logic               id_we;
	logic               id_re;
	logic [LW+IW-1:0]   id_wr_addr;
	logic [LW+IW-1:0]   id_rd_addr;
	logic [SW-1:0]      id_rd_data;

	logic               out_valid_q;
	out_t               out_data_q;

	// four radix-2 reduction steps per cycle
	always_comb begin
		mod_acc = mod_r_q;
		for (int b = 0; b < DIG_BITS; b++) begin
			mod_acc = {mod_acc[LW-1:0], mod_sh_q[KEY_W-1-b]};
			if (mod_acc >= (LW+1)'(LINES)) begin
				mod_acc = mod_acc - (LW+1)'(LINES);
			end
		end
		mod_r_d = mod_acc;
	end

	assign line = DIRECT ? key_q[LW-1:0] : mod_r_q[LW-1:0];

	// store path
	assign st_line  = first_q ? line    : open_line_q;
	assign st_key   = first_q ? key_q   : open_key_q;
	assign st_frame = first_q ? frame_q : open_frame_q;
	assign base_cnt = first_q ? '0      : open_cnt_q;
	assign base_ovf = first_q ? 1'b0    : open_ovf_q;
	assign room     = base_cnt < CW'(MAX_IDS);
	assign new_cnt  = (present_q && room) ? base_cnt + 1'b1 : base_cnt;
	assign new_ovf  = base_ovf | (present_q && !room);

	assign tag_we      = cmd.clr_wr || cmd.store_wr;
	assign tag_wr_addr = cmd.clr_wr ? clr_idx_q : st_line;
	assign tag_wr_data = cmd.clr_wr ? '0 : {st_key, st_frame, new_cnt, new_ovf};

	assign tag_key   = tag_rd_data[TAG_W-1 -: KEY_W];
	assign tag_frame = tag_rd_data[CW+1 +: FRAME_W];
	assign tag_cnt   = tag_rd_data[1 +: CW];
	assign tag_ovf   = tag_rd_data[0];

	assign id_we      = cmd.store_wr && present_q && room;
	assign id_wr_addr = {st_line, base_cnt[IW-1:0]};
	assign idx_next   = idx_q + 1'b1;
	assign id_re      = cmd.id_rd_first || cmd.id_rd_next;
	assign id_rd_addr = {line, cmd.id_rd_first ? IW'(0) : idx_next[IW-1:0]};

	fsqc_ram #(
		.WIDTH (TAG_W),
		.DEPTH (LINES)
	) u_tag_ram (
		.clk     (clk),
		.wr_en   (tag_we),
		.wr_addr (tag_wr_addr),
		.wr_data (tag_wr_data),
		.rd_en   (cmd.tag_rd),
		.rd_addr (line),
		.rd_data (tag_rd_data)
	);

	fsqc_ram #(
		.WIDTH (SW),
		.DEPTH (ID_DEPTH)
	) u_id_ram (
		.clk     (clk),
		.wr_en   (id_we),
		.wr_addr (id_wr_addr),
		.wr_data (eid_q),
		.rd_en   (id_re),
		.rd_addr (id_rd_addr),
		.rd_data (id_rd_data)
	);

	always_comb begin
		sts             = '0;
		sts.clr_last    = clr_idx_q == LW'(LINES - 1);
		sts.line_direct = DIRECT;
		sts.in_store    = in_data.opcode;
		sts.item_store  = opcode_q;
		sts.mod_done    = mod_cnt_q == MCW'(DIGITS);
		sts.hit         = (tag_key == key_q) && (tag_frame == frame_q) && !tag_ovf;
		sts.empty       = tag_cnt == '0;
		sts.last_id     = idx_next == tag_cnt;
		sts.out_free    = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			opcode_q  <= in_data.opcode;
			key_q     <= cell_key(in_data.pos_x, in_data.pos_y, in_data.radius);
			frame_q   <= in_data.frame_number;
			first_q   <= in_data.first_of_list;
			present_q <= in_data.entity_present;
			eid_q     <= in_data.entity_id[SW-1:0];
			mod_sh_q  <= cell_key(in_data.pos_x, in_data.pos_y, in_data.radius);
			mod_r_q   <= '0;
		end else if (cmd.mod_step) begin
			mod_sh_q <= mod_sh_q << DIG_BITS;
			mod_r_q  <= mod_r_d;
		end
		if (cmd.out_single) begin
			out_data_q.hit      <= sts.hit;
			out_data_q.found_id <= '0;
			out_data_q.id_valid <= 1'b0;
			out_data_q.last     <= 1'b1;
		end else if (cmd.out_id) begin
			out_data_q.hit      <= 1'b1;
			out_data_q.found_id <= OUT_ID_W'(id_rd_data);
			out_data_q.id_valid <= 1'b1;
			out_data_q.last     <= sts.last_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q    <= '0;
			mod_cnt_q    <= '0;
			idx_q        <= '0;
			open_line_q  <= '0;
			open_key_q   <= '0;
			open_frame_q <= '0;
			open_cnt_q   <= '0;
			open_ovf_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (cmd.accept) begin
				mod_cnt_q <= '0;
			end else if (cmd.mod_step) begin
				mod_cnt_q <= mod_cnt_q + 1'b1;
			end
			if (cmd.id_rd_first) begin
				idx_q <= '0;
			end else if (cmd.id_rd_next) begin
				idx_q <= idx_next;
			end
			if (cmd.store_wr) begin
				open_line_q  <= st_line;
				open_key_q   <= st_key;
				open_frame_q <= st_frame;
				open_cnt_q   <= new_cnt;
				open_ovf_q   <= new_ovf;
			end
			if (cmd.out_single || cmd.out_id) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ----- tb/sv/fsqc_response_checker.sv -----
// response checker of the frame-stamped query cache: watches both channels, predicts and compares
module fsqc_response_checker #(
	parameter int LINES   = 64,
	parameter int MAX_IDS = 32,
	parameter int ID_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  fsqc_pkg::in_t  in_data,
	input  logic           out_valid,
	input  logic           out_ready,
	input  fsqc_pkg::out_t out_data,
	output int             fail_count,
	output int             awaited
);
	import fsqc_pkg::*;

	localparam int          ROW_BITS   = $clog2(LINES);
	localparam logic [63:0] ID_MASK    = {64{1'b1}} >> (64 - ID_BITS);
	// a lookup is taken only once the previous one has loaded its last result
	localparam int          FIFO_DEPTH = 2 * MAX_IDS + 2;

	logic [KEY_W-1:0]    row_key      [LINES];
	logic [FRAME_W-1:0]  row_frame    [LINES];
	int                  row_count    [LINES];
	logic                row_overflow [LINES];
	logic [63:0]         row_ids      [LINES][MAX_IDS];
	logic [ROW_BITS-1:0] open_row;
	out_t                awaited_results [FIFO_DEPTH];
	int                  wr_ptr;
	int                  rd_ptr;
	int                  held;

	// cell quantisation toward zero, then the three cells folded into one key
	function automatic logic [KEY_W-1:0] cell_key(in_t it);
		logic signed [POS_W-1:0] qx, qy;
		logic signed [63:0]      wx, wy;
		logic [63:0]             wr;
		qx = $signed(it.pos_x) / 32'sd128;
		qy = $signed(it.pos_y) / 32'sd128;
		wx = qx;
		wy = qy;
		wr = 64'(it.radius / 24'd128);
		return wx ^ (wy << QY_SHIFT) ^ (wr << QR_SHIFT);
	endfunction

	function automatic void queue_result(out_t r);
		if (held < FIFO_DEPTH) begin
			awaited_results[wr_ptr] = r;
			wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
			held++;
		end else begin
			fail_count++;
		end
	endfunction

	function automatic void take_item(in_t it);
		logic [KEY_W-1:0]    key;
		logic [ROW_BITS-1:0] row, tgt;
		int                  i;
		key = cell_key(it);
		row = ROW_BITS'(key % 64'(LINES));
		if (it.opcode == OP_STORE) begin
			if (it.first_of_list) begin
				row_key[row]      = key;
				row_frame[row]    = it.frame_number;
				row_count[row]    = 0;
				row_overflow[row] = 1'b0;
				open_row          = row;
			end
			tgt = open_row;
			if (it.entity_present) begin
				if (row_count[tgt] < MAX_IDS) begin
					row_ids[tgt][row_count[tgt]] = 64'(it.entity_id) & ID_MASK;
					row_count[tgt]++;
				end else begin
					row_overflow[tgt] = 1'b1;
				end
			end
		end else if (row_key[row] == key && row_frame[row] == it.frame_number &&
				!row_overflow[row]) begin
			if (row_count[row] == 0) begin
				queue_result(out_t'{hit: 1'b1, found_id: '0, id_valid: 1'b0,
					last: 1'b1});
			end else begin
				for (i = 0; i < row_count[row]; i++) begin
					queue_result(out_t'{hit: 1'b1,
						found_id: row_ids[row][i][OUT_ID_W-1:0], id_valid: 1'b1,
						last: (i == row_count[row] - 1)});
				end
			end
		end else begin
			queue_result(out_t'{hit: 1'b0, found_id: '0, id_valid: 1'b0,
				last: 1'b1});
		end
	endfunction

	function automatic void note_failure(string what, out_t want, out_t got);
		if (fail_count < 10) begin
			$display("%0s: expected hit=%0b id=%h valid=%0b last=%0b,",
				what, want.hit, want.found_id, want.id_valid, want.last);
			$display("    got hit=%0b id=%h valid=%0b last=%0b",
				got.hit, got.found_id, got.id_valid, got.last);
		end
		fail_count++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		int   i;
		if (!arst_n) begin
			for (i = 0; i < LINES; i++) begin
				row_key[i]      = '0;
				row_frame[i]    = '0;
				row_count[i]    = 0;
				row_overflow[i] = 1'b0;
			end
			open_row = '0;
			wr_ptr = 0;
			rd_ptr = 0;
			held = 0;
			fail_count = 0;
			awaited <= 0;
		end else begin
			if (in_valid && in_ready) begin
				take_item(in_data);
			end
			if (out_valid && out_ready) begin
				if (held == 0) begin
					note_failure("unexpected result", '0, out_data);
				end else begin
					want = awaited_results[rd_ptr];
					rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
					held--;
					if (out_data.hit !== want.hit || out_data.found_id !== want.found_id ||
							out_data.id_valid !== want.id_valid || out_data.last !== want.last) begin
						note_failure("result mismatch", want, out_data);
					end
				end
			end
			awaited <= held;
		end
	end

endmodule

// ----- tb/sv/frame_stamped_query_cache_top_test.sv -----
// testbench top of the frame-stamped query cache: stimulus, handshake idling and verdict
module frame_stamped_query_cache_top_test;
	import fsqc_pkg::*;

	localparam int LINES        = 64;
	localparam int MAX_IDS      = 32;
	localparam int ID_BITS      = 32;
	localparam int RANDOM_ITEMS = 160;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 64;
	// moving x by this many units shifts qx by LINES cells: same line, other key
	localparam logic [POS_W-1:0] ROW_SPAN = POS_W'(LINES * 128);

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [RAD_W-1:0] r;
	} cell_query_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	int   fail_count;
	int   awaited;

	// idling rates in percent, changed as the run moves through its phases
	int tx_idle_pct = 32;
	int rx_idle_pct = 54;
	int sent        = 0;
	int cycles      = 0;

	// recently stored queries, so that later lookups can hit them
	cell_query_t    pool_q [4];
	logic [FRAME_W-1:0] pool_f [4];
	logic [FRAME_W-1:0] frame_now;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	frame_stamped_query_cache_top #(
		.LINES   (LINES),
		.MAX_IDS (MAX_IDS),
		.ID_BITS (ID_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	fsqc_response_checker #(
		.LINES   (LINES),
		.MAX_IDS (MAX_IDS),
		.ID_BITS (ID_BITS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.fail_count (fail_count),
		.awaited    (awaited)
	);

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// watchdog: a hung handshake or lost result ends the run here
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// positions: mostly anything, often near zero to cross cell edges, now and then the extremes
	function automatic logic [POS_W-1:0] rand_pos();
		case ($urandom_range(0, 7))
			0, 1:    rand_pos = POS_W'($urandom_range(0, 2047)) - 32'd1024;
			2:       rand_pos = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: rand_pos = $urandom();
		endcase
	endfunction

	function automatic cell_query_t rand_query();
		cell_query_t q;
		q.x = rand_pos();
		q.y = rand_pos();
		q.r = ($urandom_range(0, 3) == 0) ? RAD_W'($urandom_range(0, 1023)) : RAD_W'($urandom());
		return q;
	endfunction

	// one transfer on the input channel; valid is only lowered for a sender gap
	task automatic push_item(input in_t item);
		if (sent < 70) begin
			tx_idle_pct = 32;
			rx_idle_pct = 54;
		end else if (sent < 140) begin
			tx_idle_pct = 54;
			rx_idle_pct = 32;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		// in_ready read here still holds its value from before the edge
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// lookups carry random store fields, which the block must ignore
	task automatic lookup_query(input cell_query_t q, input logic [FRAME_W-1:0] f);
		in_t it;
		it.opcode         = OP_LOOKUP;
		it.pos_x          = q.x;
		it.pos_y          = q.y;
		it.radius         = q.r;
		it.frame_number   = f;
		it.first_of_list  = 1'($urandom_range(0, 1));
		it.entity_present = 1'($urandom_range(0, 1));
		it.entity_id      = $urandom();
		push_item(it);
	endtask

	task automatic store_entry(input logic first, input logic present,
			input logic [ENTITY_W-1:0] id, input cell_query_t q, input logic [FRAME_W-1:0] f);
		in_t it;
		it.opcode         = OP_STORE;
		it.pos_x          = q.x;
		it.pos_y          = q.y;
		it.radius         = q.r;
		it.frame_number   = f;
		it.first_of_list  = first;
		it.entity_present = present;
		it.entity_id      = id;
		push_item(it);
	endtask

	initial begin
		cell_query_t q0, qe, qb, qc, q;
		int          start, slot, len, k, pick, long_lists;
		in_valid <= 1'b0;
		in_data  <= '0;
		arst_n   <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed part; the clearing pass after reset simply holds off the first transfer
		q0 = '0;
		qe = cell_query_t'{x: 32'h7fff_ffff, y: 32'h8000_0000, r: 24'hff_ffff};
		qb = cell_query_t'{x: 32'd1000, y: 32'hffff_fc18, r: 24'd300};   // y is -1000
		qc = qb;
		qc.x = qb.x + ROW_SPAN;
		// fresh lines hold key 0 in frame 0, so the zero query hits an empty list
		lookup_query(q0, 32'd0);
		// +127 and -127 both truncate toward zero, still key 0
		lookup_query(cell_query_t'{x: 32'd127, y: 32'hffff_ff81, r: 24'd127}, 32'd0);
		// -128 is one cell below zero: key of all ones, miss
		lookup_query(cell_query_t'{x: 32'hffff_ff80, y: 32'd0, r: 24'd0}, 32'd0);
		// continuation before any first item lands on line 0
		store_entry(1'b0, 1'b1, 32'hffff_ffff, rand_query(), $urandom());
		lookup_query(q0, 32'd0);
		// extreme fields, a list of two followed by one empty continuation
		store_entry(1'b1, 1'b1, 32'h0000_0000, qe, 32'hffff_ffff);
		store_entry(1'b0, 1'b1, 32'h5a5a_5a5a, rand_query(), $urandom());
		store_entry(1'b0, 1'b0, $urandom(), rand_query(), $urandom());
		lookup_query(qe, 32'hffff_ffff);
		// stale frame misses
		lookup_query(qe, 32'd0);
		// stored empty list hits with no id
		store_entry(1'b1, 1'b0, $urandom(), qb, 32'd7);
		lookup_query(qb, 32'd7);
		// same line, different key: miss, then eviction
		lookup_query(qc, 32'd7);
		store_entry(1'b1, 1'b1, 32'd1, qc, 32'd7);
		lookup_query(qb, 32'd7);
		lookup_query(qc, 32'd7);

		// random part: list stores with follow-up lookups, plus stale, colliding and stray traffic
		frame_now  = $urandom();
		long_lists = 0;
		for (k = 0; k < 4; k++) begin
			pool_q[k] = rand_query();
			pool_f[k] = frame_now;
		end
		start = sent;
		while (sent - start < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (long_lists < 2 || pick < 45) begin
				slot = $urandom_range(0, 3);
				if ($urandom_range(0, 2) == 0) begin
					pool_q[slot] = rand_query();
				end
				pool_f[slot] = frame_now;
				// the first two lists fill a line exactly and then one past it
				if (long_lists < 2) begin
					len = (long_lists == 0) ? MAX_IDS : MAX_IDS + 1;
					long_lists++;
				end else if ($urandom_range(0, 9) == 0) begin
					len = $urandom_range(MAX_IDS - 2, MAX_IDS + 3);
				end else begin
					len = $urandom_range(0, 5);
				end
				store_entry(1'b1, len > 0, $urandom(), pool_q[slot], pool_f[slot]);
				for (k = 1; k < len; k++) begin
					store_entry(1'b0, 1'b1, $urandom(), rand_query(), $urandom());
				end
				if (len >= MAX_IDS || $urandom_range(0, 9) < 7) begin
					lookup_query(pool_q[slot], pool_f[slot]);
				end
			end else if (pick < 75) begin
				slot = $urandom_range(0, 3);
				lookup_query(pool_q[slot], pool_f[slot]);
			end else if (pick < 85) begin
				slot = $urandom_range(0, 3);
				q = pool_q[slot];
				case ($urandom_range(0, 2))
					0: lookup_query(q, pool_f[slot] + 32'd1);
					1: begin
						q.x = q.x + ROW_SPAN;
						lookup_query(q, pool_f[slot]);
					end
					default: begin
						// new frame: everything stored so far goes stale
						frame_now = frame_now + 32'd1;
						lookup_query(q, frame_now);
					end
				endcase
			end else if (pick < 93) begin
				lookup_query(rand_query(), $urandom_range(0, 1) ? frame_now : $urandom());
			end else begin
				store_entry(1'b0, 1'($urandom_range(0, 1)), $urandom(), rand_query(),
					$urandom());
			end
		end
		in_valid <= 1'b0;

		// drain: every predicted result out, then a quiet spell to catch strays
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
